// ----- design/rbi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types, codes and saturating helpers of the rigid body integrator.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int CFG_IDX_W     = 3;
    localparam int PARAM_W       = 31;

    localparam logic [1:0] KIND_STATIC    = 2'd0;
    localparam logic [1:0] KIND_DYNAMIC   = 2'd1;
    localparam logic [1:0] KIND_KINEMATIC = 2'd2;

    localparam logic ACT_FORCE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BODY_KIND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_INERTIA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_LINEAR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_ANGULAR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIME    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVER,
        ST_MUL,
        ST_WB,
        ST_FINAL,
        ST_PUSH
    } rbi_state_t;

    typedef enum logic [4:0] {
        OP_T1,
        OP_T2,
        OP_DVX,
        OP_DVY,
        OP_DW,
        OP_FX,
        OP_VX,
        OP_FY,
        OP_VY,
        OP_TQ,
        OP_W,
        OP_PX,
        OP_PY,
        OP_ROT,
        OP_SQX,
        OP_SQY,
        OP_SQW
    } rbi_op_t;

    typedef struct packed {
        rbi_state_t state;
        rbi_op_t    op;
        logic       out_load;
    } rbi_ctrl_t;

    localparam logic signed [PROD_W-1:0] WIDE_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] WIDE_MIN = -PROD_W'(64'sd2147483648);

    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > WIDE_MAX) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < WIDE_MIN) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0]   s;
        logic signed [DATA_W-1:0] r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_diff(input logic signed [DATA_W-1:0] a,
                                                          input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0]   s;
        logic signed [DATA_W-1:0] r;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/rigid_body_integrator_unit.sv -----
// ----------------------------------------------------------------------------
// rigid_body_integrator_unit
// Semi-implicit Euler integrator for one 2D rigid body in signed fixed point.
// ----------------------------------------------------------------------------
// Each accepted item returns one result holding the body state after it. All
// products go through one shared 32x32 multiplier whose product is registered.
// A tick on an awake dynamic body runs fifteen products, an apply-force on a
// dynamic body runs two and any other item none. The block works on one item
// at a time; its result waits in an output register, so the next item is taken
// while that result is still pending. Configuration writes are taken in any
// cycle and are expected only while the block is idle.
module rigid_body_integrator_unit #(
    parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rbi_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rbi_pkg::DATA_W-1:0]             cfg_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_action,
    input  logic signed [rbi_pkg::DATA_W-1:0]      s_force_x,
    input  logic signed [rbi_pkg::DATA_W-1:0]      s_force_y,
    input  logic signed [rbi_pkg::DATA_W-1:0]      s_point_x,
    input  logic signed [rbi_pkg::DATA_W-1:0]      s_point_y,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_position_x,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_position_y,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_angle,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_velocity_x,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_velocity_y,
    output logic signed [rbi_pkg::DATA_W-1:0]      m_spin,
    output logic                                   m_awake
);

    localparam int DW      = rbi_pkg::DATA_W;
    localparam int PW      = rbi_pkg::PROD_W;
    localparam int QW      = rbi_pkg::PARAM_W;
    localparam int DRAG_W  = FRAC_BITS + 1;
    localparam int ONE     = 1 << FRAC_BITS;
    localparam int DT_RST  = ONE / 60;
    localparam int LIM_RST = ONE / 100;
    localparam int SLP_RST = ONE / 2;

    // configuration
    logic [1:0]        body_kind_reg;
    logic [QW-1:0]     inv_mass_reg;
    logic [QW-1:0]     inv_inertia_reg;
    logic [QW-1:0]     time_step_reg;
    logic [DRAG_W-1:0] drag_reg;
    logic [QW-1:0]     lin_limit_reg;
    logic [QW-1:0]     ang_limit_reg;
    logic [QW-1:0]     time_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_kind_reg   <= rbi_pkg::KIND_DYNAMIC;
            inv_mass_reg    <= QW'(ONE);
            inv_inertia_reg <= QW'(ONE);
            time_step_reg   <= QW'(DT_RST);
            drag_reg        <= DRAG_W'(ONE);
            lin_limit_reg   <= QW'(LIM_RST);
            ang_limit_reg   <= QW'(LIM_RST);
            time_limit_reg  <= QW'(SLP_RST);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rbi_pkg::REG_BODY_KIND:     body_kind_reg   <= cfg_data[1:0];
                rbi_pkg::REG_INV_MASS:      inv_mass_reg    <= cfg_data[QW-1:0];
                rbi_pkg::REG_INV_INERTIA:   inv_inertia_reg <= cfg_data[QW-1:0];
                rbi_pkg::REG_TIME_STEP:     time_step_reg   <= cfg_data[QW-1:0];
                rbi_pkg::REG_DRAG:          drag_reg        <= cfg_data[DRAG_W-1:0];
                rbi_pkg::REG_SLEEP_LINEAR:  lin_limit_reg   <= cfg_data[QW-1:0];
                rbi_pkg::REG_SLEEP_ANGULAR: ang_limit_reg   <= cfg_data[QW-1:0];
                rbi_pkg::REG_SLEEP_TIME:    time_limit_reg  <= cfg_data[QW-1:0];
            endcase
        end
    end

    // sequencer
    rbi_pkg::rbi_ctrl_t ctrl;
    logic               out_free;
    logic               awake_reg;
    logic               dynamic;
    logic               m_valid_reg;

    assign dynamic  = (body_kind_reg == rbi_pkg::KIND_DYNAMIC);
    assign out_free = !m_valid_reg || m_ready;

    rbi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .in_tick  (s_action == rbi_pkg::ACT_TICK),
        .dynamic  (dynamic),
        .awake    (awake_reg),
        .out_free (out_free),
        .in_ready (s_ready),
        .ctrl     (ctrl)
    );

    // captured item
    logic                 in_action_reg;
    logic signed [DW-1:0] in_fx_reg, in_fy_reg, in_px_reg, in_py_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_fx_reg     <= s_force_x;
            in_fy_reg     <= s_force_y;
            in_px_reg     <= s_point_x;
            in_py_reg     <= s_point_y;
        end
    end

    // body state
    logic signed [DW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [DW-1:0] rot_reg, rot_next;
    logic signed [DW-1:0] vel_x_reg, vel_x_next, vel_y_reg, vel_y_next;
    logic signed [DW-1:0] ang_vel_reg, ang_vel_next;
    logic signed [DW-1:0] acc_fx_reg, acc_fx_next, acc_fy_reg, acc_fy_next;
    logic signed [DW-1:0] acc_tq_reg, acc_tq_next;
    logic [DW-1:0]        rest_timer_reg, rest_timer_next;
    logic                 awake_next;

    // scratch
    logic signed [DW-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic signed [DW-1:0] chain_reg, chain_next;
    logic signed [PW-1:0] wide_reg, wide_next;
    logic signed [PW-1:0] ang_sq_reg, ang_sq_next;

    // shared multiplier
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] prod_shift;
    logic signed [DW-1:0] prod_sat;
    logic signed [DW-1:0] drag_op, dt_op, im_op, ii_op;

    assign drag_op = {{(DW-DRAG_W){1'b0}}, drag_reg};
    assign dt_op   = {1'b0, time_step_reg};
    assign im_op   = {1'b0, inv_mass_reg};
    assign ii_op   = {1'b0, inv_inertia_reg};

    always_comb begin
        op_a = vel_x_reg;
        op_b = dt_op;
        case (ctrl.op)
            rbi_pkg::OP_T1:  begin op_a = rx_reg;      op_b = in_fy_reg;   end
            rbi_pkg::OP_T2:  begin op_a = ry_reg;      op_b = in_fx_reg;   end
            rbi_pkg::OP_DVX: begin op_a = vel_x_reg;   op_b = drag_op;     end
            rbi_pkg::OP_DVY: begin op_a = vel_y_reg;   op_b = drag_op;     end
            rbi_pkg::OP_DW:  begin op_a = ang_vel_reg; op_b = drag_op;     end
            rbi_pkg::OP_FX:  begin op_a = acc_fx_reg;  op_b = im_op;       end
            rbi_pkg::OP_VX:  begin op_a = chain_reg;   op_b = dt_op;       end
            rbi_pkg::OP_FY:  begin op_a = acc_fy_reg;  op_b = im_op;       end
            rbi_pkg::OP_VY:  begin op_a = chain_reg;   op_b = dt_op;       end
            rbi_pkg::OP_TQ:  begin op_a = acc_tq_reg;  op_b = ii_op;       end
            rbi_pkg::OP_W:   begin op_a = chain_reg;   op_b = dt_op;       end
            rbi_pkg::OP_PX:  begin op_a = vel_x_reg;   op_b = dt_op;       end
            rbi_pkg::OP_PY:  begin op_a = vel_y_reg;   op_b = dt_op;       end
            rbi_pkg::OP_ROT: begin op_a = ang_vel_reg; op_b = dt_op;       end
            rbi_pkg::OP_SQX: begin op_a = vel_x_reg;   op_b = vel_x_reg;   end
            rbi_pkg::OP_SQY: begin op_a = vel_y_reg;   op_b = vel_y_reg;   end
            rbi_pkg::OP_SQW: begin op_a = ang_vel_reg; op_b = ang_vel_reg; end
            default:         begin op_a = vel_x_reg;   op_b = dt_op;       end
        endcase
    end

    rbi_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk       (aclk),
        .op_a       (op_a),
        .op_b       (op_b),
        .prod_shift (prod_shift),
        .prod_sat   (prod_sat)
    );

    // sleep test
    logic [DW:0]   timer_sum;
    logic [DW-1:0] timer_sat;
    logic          resting;

    assign timer_sum = {1'b0, rest_timer_reg} + {2'b0, time_step_reg};
    assign timer_sat = timer_sum[DW] ? {DW{1'b1}} : timer_sum[DW-1:0];
    assign resting   = (wide_reg < $signed({{(PW-QW){1'b0}}, lin_limit_reg}))
                    && (ang_sq_reg < $signed({{(PW-QW){1'b0}}, ang_limit_reg}));

    always_comb begin
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        rot_next        = rot_reg;
        vel_x_next      = vel_x_reg;
        vel_y_next      = vel_y_reg;
        ang_vel_next    = ang_vel_reg;
        acc_fx_next     = acc_fx_reg;
        acc_fy_next     = acc_fy_reg;
        acc_tq_next     = acc_tq_reg;
        rest_timer_next = rest_timer_reg;
        awake_next      = awake_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        chain_next      = chain_reg;
        wide_next       = wide_reg;
        ang_sq_next     = ang_sq_reg;
        case (ctrl.state)
            rbi_pkg::ST_LEVER: begin
                rx_next     = rbi_pkg::sat_diff(in_px_reg, pos_x_reg);
                ry_next     = rbi_pkg::sat_diff(in_py_reg, pos_y_reg);
                acc_fx_next = rbi_pkg::sat_sum(acc_fx_reg, in_fx_reg);
                acc_fy_next = rbi_pkg::sat_sum(acc_fy_reg, in_fy_reg);
            end
            rbi_pkg::ST_WB: begin
                case (ctrl.op)
                    rbi_pkg::OP_T1:  wide_next    = prod_shift;
                    rbi_pkg::OP_T2:  wide_next    = wide_reg - prod_shift;
                    rbi_pkg::OP_DVX: vel_x_next   = prod_sat;
                    rbi_pkg::OP_DVY: vel_y_next   = prod_sat;
                    rbi_pkg::OP_DW:  ang_vel_next = prod_sat;
                    rbi_pkg::OP_FX:  chain_next   = prod_sat;
                    rbi_pkg::OP_VX:  vel_x_next   = rbi_pkg::sat_sum(vel_x_reg, prod_sat);
                    rbi_pkg::OP_FY:  chain_next   = prod_sat;
                    rbi_pkg::OP_VY:  vel_y_next   = rbi_pkg::sat_sum(vel_y_reg, prod_sat);
                    rbi_pkg::OP_TQ:  chain_next   = prod_sat;
                    rbi_pkg::OP_W:   ang_vel_next = rbi_pkg::sat_sum(ang_vel_reg, prod_sat);
                    rbi_pkg::OP_PX:  pos_x_next   = rbi_pkg::sat_sum(pos_x_reg, prod_sat);
                    rbi_pkg::OP_PY:  pos_y_next   = rbi_pkg::sat_sum(pos_y_reg, prod_sat);
                    rbi_pkg::OP_ROT: rot_next     = rbi_pkg::sat_sum(rot_reg, prod_sat);
                    rbi_pkg::OP_SQX: wide_next    = prod_shift;
                    rbi_pkg::OP_SQY: wide_next    = wide_reg + prod_shift;
                    rbi_pkg::OP_SQW: ang_sq_next  = prod_shift;
                    default:         wide_next    = wide_reg;
                endcase
            end
            rbi_pkg::ST_FINAL: begin
                if (in_action_reg == rbi_pkg::ACT_TICK) begin
                    acc_fx_next = '0;
                    acc_fy_next = '0;
                    acc_tq_next = '0;
                    if (resting) begin
                        rest_timer_next = timer_sat;
                        if (timer_sat >= {1'b0, time_limit_reg}) begin
                            awake_next   = 1'b0;
                            vel_x_next   = '0;
                            vel_y_next   = '0;
                            ang_vel_next = '0;
                        end
                    end else begin
                        rest_timer_next = '0;
                        awake_next      = 1'b1;
                    end
                end else begin
                    acc_tq_next = rbi_pkg::sat_sum(acc_tq_reg, rbi_pkg::sat_wide(wide_reg));
                end
            end
            default: begin
                chain_next = chain_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            rot_reg        <= '0;
            vel_x_reg      <= '0;
            vel_y_reg      <= '0;
            ang_vel_reg    <= '0;
            acc_fx_reg     <= '0;
            acc_fy_reg     <= '0;
            acc_tq_reg     <= '0;
            rest_timer_reg <= '0;
            awake_reg      <= 1'b1;
        end else begin
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            rot_reg        <= rot_next;
            vel_x_reg      <= vel_x_next;
            vel_y_reg      <= vel_y_next;
            ang_vel_reg    <= ang_vel_next;
            acc_fx_reg     <= acc_fx_next;
            acc_fy_reg     <= acc_fy_next;
            acc_tq_reg     <= acc_tq_next;
            rest_timer_reg <= rest_timer_next;
            awake_reg      <= awake_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        chain_reg  <= chain_next;
        wide_reg   <= wide_next;
        ang_sq_reg <= ang_sq_next;
    end

    // output register
    logic signed [DW-1:0] m_pos_x_reg, m_pos_y_reg, m_angle_reg;
    logic signed [DW-1:0] m_vel_x_reg, m_vel_y_reg, m_spin_reg;
    logic                 m_awake_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_pos_x_reg <= pos_x_reg;
            m_pos_y_reg <= pos_y_reg;
            m_angle_reg <= rot_reg;
            m_vel_x_reg <= vel_x_reg;
            m_vel_y_reg <= vel_y_reg;
            m_spin_reg  <= ang_vel_reg;
            m_awake_reg <= awake_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_position_x = m_pos_x_reg;
    assign m_position_y = m_pos_y_reg;
    assign m_angle      = m_angle_reg;
    assign m_velocity_x = m_vel_x_reg;
    assign m_velocity_y = m_vel_y_reg;
    assign m_spin       = m_spin_reg;
    assign m_awake      = m_awake_reg;

endmodule

// ----- design/rbi_mul.sv -----
// ----------------------------------------------------------------------------
// rbi_mul
// Shared signed 32x32 multiplier with a product register, floor shift by the
// fraction width and saturation to 32 bits.
// ----------------------------------------------------------------------------
module rbi_mul #(
    parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic signed [rbi_pkg::DATA_W-1:0]   op_a,
    input  logic signed [rbi_pkg::DATA_W-1:0]   op_b,
    output logic signed [rbi_pkg::PROD_W-1:0]   prod_shift,
    output logic signed [rbi_pkg::DATA_W-1:0]   prod_sat
);

    logic signed [rbi_pkg::PROD_W-1:0] prod_reg;
    logic signed [rbi_pkg::PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign prod_sat   = rbi_pkg::sat_wide(prod_shift);

endmodule

// ----- design/rbi_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbi_ctrl
// Sequencer: walks the product list of an apply-force or a tick item through
// the shared multiplier and hands the result to the output register.
// ----------------------------------------------------------------------------
module rbi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               in_tick,
    input  logic               dynamic,
    input  logic               awake,
    input  logic               out_free,
    output logic               in_ready,
    output rbi_pkg::rbi_ctrl_t ctrl
);

    rbi_pkg::rbi_state_t state_reg, state_next;
    rbi_pkg::rbi_op_t    op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbi_pkg::ST_IDLE;
            op_reg    <= rbi_pkg::OP_T1;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            rbi_pkg::ST_IDLE: begin
                if (start) begin
                    if (!dynamic) begin
                        state_next = rbi_pkg::ST_PUSH;
                    end else if (!in_tick) begin
                        state_next = rbi_pkg::ST_LEVER;
                    end else if (awake) begin
                        state_next = rbi_pkg::ST_MUL;
                        op_next    = rbi_pkg::OP_DVX;
                    end else begin
                        state_next = rbi_pkg::ST_PUSH;
                    end
                end
            end
            rbi_pkg::ST_LEVER: begin
                state_next = rbi_pkg::ST_MUL;
                op_next    = rbi_pkg::OP_T1;
            end
            rbi_pkg::ST_MUL: begin
                state_next = rbi_pkg::ST_WB;
            end
            rbi_pkg::ST_WB: begin
                if (op_reg == rbi_pkg::OP_T2 || op_reg == rbi_pkg::OP_SQW) begin
                    state_next = rbi_pkg::ST_FINAL;
                end else begin
                    state_next = rbi_pkg::ST_MUL;
                    op_next    = rbi_pkg::rbi_op_t'(op_reg + 5'd1);
                end
            end
            rbi_pkg::ST_FINAL: begin
                state_next = rbi_pkg::ST_PUSH;
            end
            rbi_pkg::ST_PUSH: begin
                if (out_free) begin
                    state_next = rbi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rbi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = (state_reg == rbi_pkg::ST_IDLE);
        ctrl.state    = state_reg;
        ctrl.op       = op_reg;
        ctrl.out_load = (state_reg == rbi_pkg::ST_PUSH) && out_free;
    end

endmodule

// ----- design/rbi_checker.sv -----
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks of the rigid body integrator, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [rbi_pkg::DATA_W-1:0] m_position_x,
    input logic signed [rbi_pkg::DATA_W-1:0] m_position_y,
    input logic signed [rbi_pkg::DATA_W-1:0] m_angle,
    input logic signed [rbi_pkg::DATA_W-1:0] m_velocity_x,
    input logic signed [rbi_pkg::DATA_W-1:0] m_velocity_y,
    input logic signed [rbi_pkg::DATA_W-1:0] m_spin,
    input logic                              m_awake
);

    // one item in flight: no accept in back-to-back cycles
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // a sleeping body stays asleep until reset
    a_no_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_awake) |=> !m_awake)
        else $error("sleeping body reported awake again");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_position_x) && $stable(m_position_y)
            && $stable(m_angle) && $stable(m_velocity_x) && $stable(m_velocity_y)
            && $stable(m_spin) && $stable(m_awake)))
        else $error("stalled result changed");

endmodule

bind rigid_body_integrator_unit rbi_checker u_rbi_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_position_x (m_position_x),
    .m_position_y (m_position_y),
    .m_angle      (m_angle),
    .m_velocity_x (m_velocity_x),
    .m_velocity_y (m_velocity_y),
    .m_spin       (m_spin),
    .m_awake      (m_awake)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the rigid body integrator against an in-bench fixed-point predictor:
// directed force, tick, body-kind and mass cases, random traffic under four
// mixes of sender idling and receiver stalling, then a sleep case.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC          = rbi_pkg::FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int BLOCK_ITEMS   = 100;

    localparam logic [1:0]         KIND_UNUSED = 2'd3;
    localparam logic signed [31:0] FIX_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FIX_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] FIX_ONE     = 32'sh0001_0000;
    localparam logic [30:0]        PARAM_MAX   = 31'h7FFF_FFFF;
    localparam longint             SAT_HI      = 64'sd2147483647;
    localparam longint             SAT_LO      = -64'sd2147483648;
    localparam longint             TIMER_MAX   = 64'sd4294967295;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] angle;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spin;
        logic               awake;
    } body_view_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [rbi_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [rbi_pkg::DATA_W-1:0]           cfg_data  = '0;
    logic                                 s_valid   = 1'b0;
    logic                                 s_ready;
    logic                                 s_action  = rbi_pkg::ACT_FORCE;
    logic signed [rbi_pkg::DATA_W-1:0]    s_force_x = '0;
    logic signed [rbi_pkg::DATA_W-1:0]    s_force_y = '0;
    logic signed [rbi_pkg::DATA_W-1:0]    s_point_x = '0;
    logic signed [rbi_pkg::DATA_W-1:0]    s_point_y = '0;
    logic                                 m_valid;
    logic                                 m_ready   = 1'b0;
    logic signed [rbi_pkg::DATA_W-1:0]    m_position_x;
    logic signed [rbi_pkg::DATA_W-1:0]    m_position_y;
    logic signed [rbi_pkg::DATA_W-1:0]    m_angle;
    logic signed [rbi_pkg::DATA_W-1:0]    m_velocity_x;
    logic signed [rbi_pkg::DATA_W-1:0]    m_velocity_y;
    logic signed [rbi_pkg::DATA_W-1:0]    m_spin;
    logic                                 m_awake;

    // predicted configuration
    logic [1:0]  kind_reg        = rbi_pkg::KIND_DYNAMIC;
    logic [30:0] inv_mass_reg    = 31'd65536;
    logic [30:0] inv_inertia_reg = 31'd65536;
    logic [30:0] step_reg        = 31'd1092;
    logic [16:0] drag_reg        = 17'd65536;
    logic [30:0] lin_limit_reg   = 31'd655;
    logic [30:0] ang_limit_reg   = 31'd655;
    logic [30:0] rest_limit_reg  = 31'd32768;

    // predicted body state
    logic signed [31:0] body_px     = '0;
    logic signed [31:0] body_py     = '0;
    logic signed [31:0] body_rot    = '0;
    logic signed [31:0] body_vx     = '0;
    logic signed [31:0] body_vy     = '0;
    logic signed [31:0] body_spin   = '0;
    logic signed [31:0] force_acc_x = '0;
    logic signed [31:0] force_acc_y = '0;
    logic signed [31:0] torque_acc  = '0;
    logic [31:0]        rest_count  = '0;
    logic               body_awake  = 1'b1;

    body_view_t expected_states[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int item_count     = 0;
    int tick_count     = 0;
    int result_count   = 0;
    int asleep_count   = 0;
    int cycle_count    = 0;

    rigid_body_integrator_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 aclk = ~aclk;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > SAT_HI) begin
            return FIX_MAX;
        end
        if (v < SAT_LO) begin
            return FIX_MIN;
        end
        return v[31:0];
    endfunction

    function automatic longint floor_shift(input longint p);
        return p >>> FRAC;
    endfunction

    function automatic logic signed [31:0] fix_mul(input longint a, input longint b);
        return clamp32(floor_shift(a * b));
    endfunction

    function automatic logic signed [31:0] fix_add(input longint a, input longint b);
        return clamp32(a + b);
    endfunction

    function automatic void integrate_tick();
        longint vx;
        longint vy;
        longint w;
        longint lin;
        longint ang;
        longint timer;
        body_vx   = fix_mul(body_vx, drag_reg);
        body_vy   = fix_mul(body_vy, drag_reg);
        body_spin = fix_mul(body_spin, drag_reg);
        if (inv_mass_reg != 0) begin
            body_vx = fix_add(body_vx, fix_mul(fix_mul(force_acc_x, inv_mass_reg), step_reg));
            body_vy = fix_add(body_vy, fix_mul(fix_mul(force_acc_y, inv_mass_reg), step_reg));
        end
        if (inv_inertia_reg != 0) begin
            body_spin = fix_add(body_spin,
                                fix_mul(fix_mul(torque_acc, inv_inertia_reg), step_reg));
        end
        body_px  = fix_add(body_px, fix_mul(body_vx, step_reg));
        body_py  = fix_add(body_py, fix_mul(body_vy, step_reg));
        body_rot = fix_add(body_rot, fix_mul(body_spin, step_reg));
        force_acc_x = '0;
        force_acc_y = '0;
        torque_acc  = '0;
        vx  = body_vx;
        vy  = body_vy;
        w   = body_spin;
        lin = floor_shift(vx * vx) + floor_shift(vy * vy);
        ang = floor_shift(w * w);
        if (lin < longint'(lin_limit_reg) && ang < longint'(ang_limit_reg)) begin
            timer = longint'(rest_count) + longint'(step_reg);
            if (timer > TIMER_MAX) begin
                timer = TIMER_MAX;
            end
            rest_count = timer[31:0];
            if (rest_count >= {1'b0, rest_limit_reg}) begin
                body_awake = 1'b0;
                body_vx    = '0;
                body_vy    = '0;
                body_spin  = '0;
            end
        end else begin
            rest_count = '0;
            body_awake = 1'b1;
        end
    endfunction

    function automatic body_view_t advance_body(input logic act,
                                                input logic signed [31:0] fx,
                                                input logic signed [31:0] fy,
                                                input logic signed [31:0] px,
                                                input logic signed [31:0] py);
        body_view_t view;
        logic       dynamic;
        longint     rx;
        longint     ry;
        longint     fxl;
        longint     fyl;
        dynamic = (kind_reg == rbi_pkg::KIND_DYNAMIC);
        if (act == rbi_pkg::ACT_FORCE) begin
            if (dynamic) begin
                fxl = fx;
                fyl = fy;
                rx  = clamp32(longint'(px) - longint'(body_px));
                ry  = clamp32(longint'(py) - longint'(body_py));
                force_acc_x = fix_add(force_acc_x, fxl);
                force_acc_y = fix_add(force_acc_y, fyl);
                torque_acc  = fix_add(torque_acc,
                                      clamp32(floor_shift(rx * fyl) - floor_shift(ry * fxl)));
            end
        end else if (dynamic && body_awake) begin
            integrate_tick();
        end
        view.pos_x = body_px;
        view.pos_y = body_py;
        view.angle = body_rot;
        view.vel_x = body_vx;
        view.vel_y = body_vy;
        view.spin  = body_spin;
        view.awake = body_awake;
        return view;
    endfunction

    function automatic logic signed [31:0] pick_value(input int scale);
        logic signed [31:0] r;
        int                 sel;
        sel = $urandom_range(9);
        r   = $urandom;
        if (sel == 0) begin
            r = ($urandom_range(1) != 0) ? FIX_MAX : FIX_MIN;
        end else if (sel == 1) begin
            r = ($urandom_range(1) != 0) ? 32'sd0 : -32'sd1;
        end else if (sel > 2) begin
            r = r >>> (31 - scale);
        end
        return r;
    endfunction

    function automatic logic [30:0] pick_gain();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return PARAM_MAX;
        end else if (sel < 4) begin
            return 31'd65536;
        end
        return 31'($urandom_range(1 << 20, 1));
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic push_item(input logic act,
                             input logic signed [31:0] fx, input logic signed [31:0] fy,
                             input logic signed [31:0] px, input logic signed [31:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_force_x <= fx;
        s_force_y <= fy;
        s_point_x <= px;
        s_point_y <= py;
        do @(posedge aclk); while (!s_ready);
        expected_states.push_back(advance_body(act, fx, fy, px, py));
        item_count++;
        if (act == rbi_pkg::ACT_TICK) begin
            tick_count++;
        end
    endtask

    task automatic push_tick();
        push_item(rbi_pkg::ACT_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_states.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rbi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rbi_pkg::REG_BODY_KIND:     kind_reg        = value[1:0];
            rbi_pkg::REG_INV_MASS:      inv_mass_reg    = value[30:0];
            rbi_pkg::REG_INV_INERTIA:   inv_inertia_reg = value[30:0];
            rbi_pkg::REG_TIME_STEP:     step_reg        = value[30:0];
            rbi_pkg::REG_DRAG:          drag_reg        = value[16:0];
            rbi_pkg::REG_SLEEP_LINEAR:  lin_limit_reg   = value[30:0];
            rbi_pkg::REG_SLEEP_ANGULAR: ang_limit_reg   = value[30:0];
            rbi_pkg::REG_SLEEP_TIME:    rest_limit_reg  = value[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic randomize_config();
        logic [1:0]  kind;
        logic [30:0] lin;
        logic [30:0] ang;
        logic [30:0] step;
        logic [30:0] rest;
        logic [16:0] drag;
        int          sel;
        kind = ($urandom_range(99) < 90) ? rbi_pkg::KIND_DYNAMIC : 2'($urandom_range(3));
        sel  = $urandom_range(3);
        drag = (sel == 0) ? 17'd0 : (sel == 1) ? 17'd65536 : 17'($urandom_range(65536));
        if ($urandom_range(1) != 0) begin
            // resting possible: keep the timer far from the sleep limit
            lin  = 31'($urandom_range(1 << $urandom_range(30, 4), 1));
            ang  = 31'($urandom_range(1 << $urandom_range(30, 4), 1));
            sel  = $urandom_range(2);
            step = (sel == 0) ? 31'd0 : (sel == 1) ? 31'd1092 : 31'($urandom_range(65536, 1));
            rest = PARAM_MAX;
        end else begin
            lin  = ($urandom_range(1) != 0) ? 31'd0 : 31'($urandom);
            ang  = (lin != 0) ? 31'd0 : 31'($urandom);
            sel  = $urandom_range(3);
            step = (sel == 0) ? 31'd1092 : (sel == 1) ? PARAM_MAX
                                         : 31'($urandom_range(1 << 20, 1));
            rest = ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom);
        end
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, kind});
        write_reg(rbi_pkg::REG_INV_MASS, {1'b0, pick_gain()});
        write_reg(rbi_pkg::REG_INV_INERTIA, {1'b0, pick_gain()});
        write_reg(rbi_pkg::REG_TIME_STEP, {1'b0, step});
        write_reg(rbi_pkg::REG_DRAG, {15'd0, drag});
        write_reg(rbi_pkg::REG_SLEEP_LINEAR, {1'b0, lin});
        write_reg(rbi_pkg::REG_SLEEP_ANGULAR, {1'b0, ang});
        write_reg(rbi_pkg::REG_SLEEP_TIME, {1'b0, rest});
    endtask

    task automatic test_reset_state();
        push_item(rbi_pkg::ACT_FORCE, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
        push_item(rbi_pkg::ACT_FORCE, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX);
        push_item(rbi_pkg::ACT_FORCE, FIX_ONE, -32'sh0000_8000, 32'sh0002_0000, FIX_ONE);
        push_tick();
        push_tick();
    endtask

    task automatic test_body_kinds();
        drain_results();
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, rbi_pkg::KIND_STATIC});
        push_item(rbi_pkg::ACT_FORCE, FIX_ONE, FIX_ONE, FIX_ONE, -FIX_ONE);
        push_tick();
        drain_results();
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, rbi_pkg::KIND_KINEMATIC});
        push_item(rbi_pkg::ACT_FORCE, -FIX_ONE, FIX_ONE, FIX_MAX, FIX_ONE);
        push_tick();
        drain_results();
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, KIND_UNUSED});
        push_item(rbi_pkg::ACT_FORCE, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN);
        push_tick();
        drain_results();
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, rbi_pkg::KIND_DYNAMIC});
    endtask

    task automatic test_mass_extremes();
        drain_results();
        write_reg(rbi_pkg::REG_SLEEP_LINEAR, 32'd0);
        write_reg(rbi_pkg::REG_INV_MASS, 32'd0);
        write_reg(rbi_pkg::REG_INV_INERTIA, 32'd0);
        push_item(rbi_pkg::ACT_FORCE, 32'sh0004_0000, -32'sh0002_0000, 32'sh0003_0000,
                  FIX_ONE);
        push_tick();
        drain_results();
        write_reg(rbi_pkg::REG_INV_MASS, {1'b0, PARAM_MAX});
        write_reg(rbi_pkg::REG_INV_INERTIA, {1'b0, PARAM_MAX});
        write_reg(rbi_pkg::REG_TIME_STEP, {1'b0, PARAM_MAX});
        write_reg(rbi_pkg::REG_DRAG, 32'd0);
        push_item(rbi_pkg::ACT_FORCE, 32'sh0004_0000, -32'sh0002_0000, 32'sh0003_0000,
                  FIX_ONE);
        push_tick();
        push_tick();
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct);
        int scale;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int blk = 0; blk < 4; blk++) begin
            drain_results();
            randomize_config();
            scale = $urandom_range(22, 10);
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if ($urandom_range(99) < 35) begin
                    push_tick();
                end else begin
                    push_item(rbi_pkg::ACT_FORCE, pick_value(scale), pick_value(scale),
                              pick_value(scale + 2), pick_value(scale + 2));
                end
            end
        end
    endtask

    // nothing wakes a sleeping body but reset, so this runs last
    task automatic test_sleep_entry();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        write_reg(rbi_pkg::REG_BODY_KIND, {30'd0, rbi_pkg::KIND_DYNAMIC});
        write_reg(rbi_pkg::REG_DRAG, 32'd0);
        write_reg(rbi_pkg::REG_SLEEP_LINEAR, {1'b0, PARAM_MAX});
        write_reg(rbi_pkg::REG_SLEEP_ANGULAR, {1'b0, PARAM_MAX});
        write_reg(rbi_pkg::REG_TIME_STEP, FIX_ONE);
        write_reg(rbi_pkg::REG_SLEEP_TIME, 32'd3 * FIX_ONE);
        repeat (5) push_tick();
        push_item(rbi_pkg::ACT_FORCE, 32'sh0010_0000, -32'sh0010_0000, FIX_ONE, FIX_ONE);
        push_tick();
        push_item(rbi_pkg::ACT_FORCE, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MIN);
    endtask

    always @(posedge aclk) begin : result_check
        body_view_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_states.size() == 0) begin
                    $display("%0t: result transfer with no expected state pending", $time);
                    error_count++;
                end else begin
                    want = expected_states.pop_front();
                    compare_field("position_x", want.pos_x, m_position_x);
                    compare_field("position_y", want.pos_y, m_position_y);
                    compare_field("angle", want.angle, m_angle);
                    compare_field("velocity_x", want.vel_x, m_velocity_x);
                    compare_field("velocity_y", want.vel_y, m_velocity_y);
                    compare_field("spin", want.spin, m_spin);
                    compare_field("awake", 32'(want.awake), 32'(m_awake));
                    if (!want.awake) begin
                        asleep_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_body_kinds();
        test_mass_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(74, 0);
        test_random_traffic(0, 74);
        test_random_traffic(38, 38);
        test_sleep_entry();
        drain_results();
        if (expected_states.size() != 0) begin
            $display("%0t: %0d expected states never arrived", $time, expected_states.size());
            error_count++;
        end
        $display("Ran %0d items (%0d ticks), checked %0d results, %0d of them asleep.",
                 item_count, tick_count, result_count, asleep_count);
        $display("Covered all body kinds, gain and step extremes, saturation, idle mixes.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
